FILE: src/llim_pkg.sv
// Shared constants and helpers for the lookahead brickwall limiter.
// Used by llim_div and lookahead_brickwall_limiter_top.
`default_nettype none
package llim_pkg;

  localparam int MAX_DELAY = 128;
  localparam int PTR_W     = $clog2(MAX_DELAY);
  localparam int DS_W      = 8;
  localparam int DIV_N     = 61;   // dividend / quotient width
  localparam int DIV_D     = 31;   // divisor width
  localparam int DIV_CW    = $clog2(DIV_N);

  localparam logic [30:0] ONE_Q30    = 31'd1073741824;
  localparam logic [30:0] TARGET_Q30 = 31'd1084479242;   // 1.01 in Q1.30
  localparam logic signed [31:0] CLIP_Q20 = 32'sd1048576000;

  localparam logic [1:0] PH_OFF  = 2'd0;
  localparam logic [1:0] PH_ATT  = 2'd1;
  localparam logic [1:0] PH_HOLD = 2'd2;
  localparam logic [1:0] PH_REL  = 2'd3;

  localparam logic [1:0] REG_LIMIT = 2'd0;
  localparam logic [1:0] REG_DELAY = 2'd1;
  localparam logic [1:0] REG_ALPHA = 2'd2;

  function automatic logic signed [31:0] clamp_sample(input logic signed [31:0] x);
    if (x > CLIP_Q20) return CLIP_Q20;
    else if (x < -CLIP_Q20) return -CLIP_Q20;
    else return x;
  endfunction

  function automatic logic [29:0] abs_sample(input logic signed [31:0] x);
    logic signed [31:0] n;
    n = -x;
    return (x < 0) ? n[29:0] : x[29:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/lookahead_brickwall_limiter_top.sv
// Lookahead brickwall limiter, top level: delay memory, sequencer, shared multiplier.
// Depends on llim_pkg and llim_div.
//
// One stereo word is taken while the block is idle and its result word follows
// after a sequence on one shared 33x33 multiplier and one bit-serial divider.
// Each hold/release frame adds a multiplier pass (ST_RM, ST_RA) per predicted
// release step (up to delay+1 steps), and a release frame adds the ST_RELA
// state for the gain update. A frame that triggers attack runs two divides,
// plus one or two more when a running ramp is refitted. The result sits in an
// output register so the next word is accepted while it waits. Delay memory
// starts as zeros (per-row valid bits, no clearing pass).
`default_nettype none
module lookahead_brickwall_limiter_top import llim_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // sample_left, sample_right
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,   // out_left, out_right, gain_now, pad
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);

  localparam logic [4:0] ST_IDLE = 5'd0,  ST_MEM = 5'd1,  ST_PG  = 5'd2,  ST_CK  = 5'd3,
                         ST_RM   = 5'd4,  ST_RA  = 5'd5,  ST_PRM = 5'd6,  ST_PR  = 5'd7,
                         ST_T    = 5'd8,  ST_MAG = 5'd9,  ST_K   = 5'd10, ST_KC  = 5'd11,
                         ST_UPD  = 5'd12, ST_RELA = 5'd13, ST_SL = 5'd14, ST_SR  = 5'd15,
                         ST_SW   = 5'd16, ST_DONE = 5'd17;

  // configuration
  logic [30:0]     limit;
  logic [DS_W-1:0] delay_samples;
  logic [29:0]     alpha_release;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit         <= 31'd1048576;
      delay_samples <= 8'd96;
      alpha_release <= 30'd1073518151;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIMIT: limit         <= cfg_data;
        REG_DELAY: delay_samples <= cfg_data[DS_W-1:0];
        REG_ALPHA: alpha_release <= cfg_data[29:0];
        default: ;
      endcase
    end
  end

  logic [DS_W-1:0]  d;
  logic [PTR_W-1:0] len;
  always_comb begin
    if (delay_samples == '0) d = DS_W'(1);
    else if (delay_samples > DS_W'(MAX_DELAY)) d = DS_W'(MAX_DELAY);
    else d = delay_samples;
    len = PTR_W'(d - 1'b1);
  end

  // state
  logic [4:0]         state;
  logic [PTR_W-1:0]   ptr;
  logic [30:0]        gain;
  logic [1:0]         phase;
  logic [30:0]        amag;          // attack step magnitude
  logic [DS_W-1:0]    attack_left;
  logic [DS_W-1:0]    hold_left;
  logic [MAX_DELAY-1:0] row_vld;

  logic signed [31:0] xl, xr;
  logic [29:0]        peak;
  logic [31:0]        pg;
  logic [61:0]        cterm;
  logic [30:0]        mg;
  logic [DS_W-1:0]    n;
  logic [30:0]        diff;
  logic signed [31:0] ol, orr;
  logic               rd_ok;

  // input side
  logic               accept;
  logic signed [31:0] cl, cr;
  logic [29:0]        al, ar;
  logic [PTR_W-1:0]   ptr_use;
  logic [PTR_W:0]     ptr_inc;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cl = clamp_sample(s_axis_tdata[31:0]);
    cr = clamp_sample(s_axis_tdata[63:32]);
    al = abs_sample(cl);
    ar = abs_sample(cr);
    ptr_use = (ptr >= len) ? '0 : ptr;
    ptr_inc = {1'b0, ptr_use} + 1'b1;
  end

  // delay memory: one row holds both channels
  logic [63:0] mem [MAX_DELAY];
  logic [63:0] rd;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd <= mem[ptr_use];
      if (len != '0) mem[ptr_use] <= {cr, cl};
    end
  end

  logic signed [31:0] dl, dr;
  always_comb begin
    if (len == '0) begin
      dl = xl;
      dr = xr;
    end else if (rd_ok) begin
      dl = rd[31:0];
      dr = rd[63:32];
    end else begin
      dl = '0;
      dr = '0;
    end
  end

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MEM:  begin mul_a = {3'b0, peak}; mul_b = {2'b0, gain}; end
      ST_PG:   begin
        mul_a = {2'b0, ONE_Q30 - {1'b0, alpha_release}};
        mul_b = {2'b0, TARGET_Q30};
      end
      ST_RM:   begin mul_a = {2'b0, mg}; mul_b = {3'b0, alpha_release}; end
      ST_PRM:  begin mul_a = {3'b0, peak}; mul_b = {2'b0, mg}; end
      ST_UPD:  begin mul_a = {2'b0, gain}; mul_b = {3'b0, alpha_release}; end
      ST_SL:   begin mul_a = {dl[31], dl}; mul_b = {2'b0, gain}; end
      ST_SR:   begin mul_a = {dr[31], dr}; mul_b = {2'b0, gain}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) prod <= mul_a * mul_b;

  // release update and saturation from the product register
  logic [62:0]        rsum;
  logic signed [65:0] prnd;
  logic signed [35:0] sq;
  logic signed [31:0] sat;
  always_comb begin
    rsum = {1'b0, prod[61:0]} + {1'b0, cterm};
    // round half up, then floor
    prnd = prod + 66'sd536870912;
    sq   = prnd[65:30];
    if (sq > 36'sd2147483647) sat = 32'sh7FFFFFFF;
    else if (sq < -36'sd2147483648) sat = 32'sh80000000;
    else sat = sq[31:0];
  end

  // divider
  logic             div_go;
  logic [DIV_N-1:0] div_dnd;
  logic [DIV_D-1:0] div_dsr;
  logic             div_done;
  logic [DIV_N-1:0] quo;

  llim_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_dnd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (quo)
  );

  // sequencer helpers
  logic [31:0]     pr;
  logic [30:0]     dsum;
  logic [DS_W-1:0] kc;
  logic [31:0]     gsub;
  logic [DS_W-1:0] n_init;

  always_comb begin
    pr = (phase == PH_HOLD || phase == PH_REL) ? prod[61:30] : pg;
    dsum = diff;
    if (quo == '0) kc = DS_W'(1);
    else if (quo > DIV_N'(d)) kc = d;
    else kc = quo[DS_W-1:0];
    gsub = {1'b0, gain} - {1'b0, amag};
    if (phase == PH_REL) n_init = d + 1'b1;
    else if (phase == PH_HOLD) n_init = (hold_left <= d) ? d - hold_left + 1'b1 : '0;
    else n_init = '0;
  end

  logic [30:0] t_diff;
  always_comb begin
    t_diff = (quo >= DIV_N'(gain)) ? '0 : gain - quo[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ptr           <= '0;
      gain          <= ONE_Q30;
      phase         <= PH_OFF;
      amag          <= '0;
      attack_left   <= '0;
      hold_left     <= '0;
      row_vld       <= '0;
      div_go        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // start is a one-cycle pulse; it is never raised while still high
      if (div_go) div_go <= 1'b0;
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            xl    <= cl;
            xr    <= cr;
            peak  <= (al > ar) ? al : ar;
            rd_ok <= row_vld[ptr_use];
            if (len != '0) begin
              row_vld[ptr_use] <= 1'b1;
              ptr <= (ptr_inc >= {1'b0, len}) ? '0 : ptr_inc[PTR_W-1:0];
            end else begin
              ptr <= ptr_use;
            end
            state <= ST_MEM;
          end
        end
        ST_MEM: state <= ST_PG;
        ST_PG: begin
          pg    <= prod[61:30];
          state <= ST_CK;
        end
        ST_CK: begin
          cterm <= prod[61:0];
          mg    <= gain;
          n     <= n_init;
          state <= (n_init == '0) ? ST_PRM : ST_RM;
        end
        ST_RM: state <= ST_RA;
        ST_RA: begin
          mg    <= rsum[60:30];
          n     <= n - 1'b1;
          state <= (n == DS_W'(1)) ? ST_PRM : ST_RM;
        end
        ST_PRM: state <= ST_PR;
        ST_PR: begin
          if (pg > {1'b0, limit}) begin
            // peak is nonzero whenever pg exceeds the limit
            phase   <= PH_ATT;
            div_go  <= 1'b1;
            div_dnd <= {limit, 30'b0};
            div_dsr <= {1'b0, peak};
            state   <= ST_T;
          end else begin
            if (pr > {1'b0, limit}) begin
              phase     <= PH_HOLD;
              hold_left <= d;
            end
            state <= ST_UPD;
          end
        end
        ST_T: begin
          if (div_done) begin
            diff    <= t_diff;
            div_go  <= 1'b1;
            div_dnd <= DIV_N'(t_diff + 31'(d) - 31'd1);
            div_dsr <= DIV_D'(d);
            state   <= ST_MAG;
          end
        end
        ST_MAG: begin
          if (div_done) begin
            if (quo[30:0] > amag) begin
              attack_left <= d;
              amag        <= quo[30:0];
              state       <= ST_UPD;
            end else if (amag != '0) begin
              div_go  <= 1'b1;
              div_dnd <= DIV_N'(dsum);
              div_dsr <= amag;
              state   <= ST_K;
            end else begin
              state <= ST_UPD;
            end
          end
        end
        ST_K: begin
          if (div_done) begin
            if (kc > attack_left) begin
              attack_left <= kc;
              div_go      <= 1'b1;
              div_dnd     <= DIV_N'(dsum + 31'(kc) - 31'd1);
              div_dsr     <= DIV_D'(kc);
              state       <= ST_KC;
            end else begin
              state <= ST_UPD;
            end
          end
        end
        ST_KC: begin
          if (div_done) begin
            amag  <= quo[30:0];
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          case (phase)
            PH_ATT: begin
              gain  <= gsub[31] ? '0 : gsub[30:0];
              state <= ST_SL;
              if (attack_left <= DS_W'(1)) begin
                attack_left <= '0;
                phase       <= PH_HOLD;
                hold_left   <= d;
                amag        <= '0;
              end else begin
                attack_left <= attack_left - 1'b1;
              end
            end
            PH_HOLD: begin
              state <= ST_SL;
              if (hold_left <= DS_W'(1)) begin
                hold_left <= '0;
                phase     <= PH_REL;
              end else begin
                hold_left <= hold_left - 1'b1;
              end
            end
            PH_REL: state <= ST_RELA;
            default: state <= ST_SL;
          endcase
        end
        ST_RELA: begin
          if (rsum[61:30] >= {1'b0, ONE_Q30}) begin
            gain  <= ONE_Q30;
            phase <= PH_OFF;
          end else begin
            gain <= rsum[60:30];
          end
          state <= ST_SL;
        end
        ST_SL: state <= ST_SR;
        ST_SR: begin
          ol    <= sat;
          state <= ST_SW;
        end
        ST_SW: begin
          orr   <= sat;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {1'b0, gain, orr, ol};
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/llim_div.sv
// Restoring divider, one quotient bit per cycle, shared by the limiter sequencer.
// Depends on llim_pkg for widths.
`default_nettype none
module llim_div import llim_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_N-1:0]  dividend,
  input  wire logic [DIV_D-1:0]  divisor,
  output logic                   done,
  output logic [DIV_N-1:0]       quotient
);

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_D-1:0]  rem;
  logic [DIV_D-1:0]  dsr;
  logic [DIV_D:0]    trial;
  logic [DIV_D:0]    diff;
  logic              qbit;

  always_comb begin
    trial = {rem, quotient[DIV_N-1]};
    diff  = trial - {1'b0, dsr};
    qbit  = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
        cnt      <= DIV_CW'(DIV_N - 1);
      end else if (busy) begin
        rem      <= qbit ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
        quotient <= {quotient[DIV_N-2:0], qbit};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire
